// ===== rtl/core/ttlex_pkg.sv =====
`timescale 1ns / 1ps

package ttlex_pkg;

    // result event codes
    localparam logic [2:0] EV_CHAR  = 3'd0;
    localparam logic [2:0] EV_DONE  = 3'd1;
    localparam logic [2:0] EV_OPEN  = 3'd2;
    localparam logic [2:0] EV_CLOSE = 3'd3;
    localparam logic [2:0] EV_ERROR = 3'd4;

    // token kinds
    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_NUMBER = 2'd1;
    localparam logic [1:0] KIND_STRING = 2'd2;
    localparam logic [1:0] KIND_IDENT  = 2'd3;

    // error kinds
    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SIGN   = 2'd1;
    localparam logic [1:0] ERR_ESCAPE = 2'd2;
    localparam logic [1:0] ERR_UNTERM = 2'd3;

    // request mode
    localparam logic MODE_CHAR = 1'b0;
    localparam logic MODE_END  = 1'b1;

    // reported line width
    localparam int LINE_OUT_BITS = 24;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // one result without its line
    typedef struct packed {
        logic [2:0] ev;
        logic [1:0] kind;
        logic [7:0] chr;
        logic [1:0] err;
    } res_t;

    // one or two results caused by a request
    typedef struct packed {
        logic                     two;
        res_t                     r0;
        res_t                     r1;
        logic [LINE_OUT_BITS-1:0] line;
    } entry_t;

    // front status
    typedef struct packed {
        logic push;
        logic halted;
    } front_stat_t;

endpackage

// ===== rtl/core/text_token_lexer.sv =====
`timescale 1ns / 1ps

// channel   ports                                               direction
// request   s_valid s_ready s_mode s_ch                         in
// result    m_valid m_ready m_event_res m_token_kind            out
//           m_char_value m_line_number m_error_kind m_last
//
// One request is taken per cycle while the front-to-back queue has room.
// A request gives zero, one or two results; the output stage sends one per
// cycle while m_ready is high, so a request with two results holds the result
// port for both. A result passes the queue and then the output register.
// Reset is synchronous; after an error result all requests are taken and
// dropped until reset. Stalls on the result side fill the two-entry queue
// before s_ready drops.

module text_token_lexer #(
    parameter int LINE_BITS = 24
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_mode,
    input  logic [7:0]  s_ch,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_event_res,
    output logic [1:0]  m_token_kind,
    output logic [7:0]  m_char_value,
    output logic [23:0] m_line_number,
    output logic [1:0]  m_error_kind,
    output logic        m_last
);

    ttlex_pkg::entry_t      fr_entry;
    ttlex_pkg::front_stat_t fr_stat;
    ttlex_pkg::entry_t      q_entry;
    ttlex_pkg::res_t        out_res;
    logic                   q_not_full;
    logic                   q_valid;
    logic                   q_pop;
    logic                   in_accept;

    assign s_ready   = q_not_full;
    assign in_accept = s_valid && s_ready;

    // classify each byte
    ttlex_front #(
        .LINE_BITS(LINE_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_accept(in_accept),
        .in_mode  (s_mode),
        .in_ch    (s_ch),
        .entry    (fr_entry),
        .stat     (fr_stat)
    );

    // decoupling queue
    ttlex_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (fr_stat.push),
        .wr_entry(fr_entry),
        .not_full(q_not_full),
        .pop     (q_pop),
        .rd_valid(q_valid),
        .rd_entry(q_entry)
    );

    // serialize results
    ttlex_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_res  (out_res),
        .out_line (m_line_number),
        .out_last (m_last)
    );

    assign m_event_res  = out_res.ev;
    assign m_token_kind = out_res.kind;
    assign m_char_value = out_res.chr;
    assign m_error_kind = out_res.err;

    // a push only lands when the queue has room
    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        fr_stat.push |-> q_not_full)
        else $error("push into full queue");

    // an error on the output means the front has already halted
    a_err_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == ttlex_pkg::EV_ERROR) |-> fr_stat.halted)
        else $error("error result without halt");

    // an error closes the results of its request
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_event_res == ttlex_pkg::EV_ERROR) |-> m_last)
        else $error("error result not last");

    // a halted front pushes nothing
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        fr_stat.halted |-> !fr_stat.push)
        else $error("push after halt");

endmodule

// ===== rtl/core/ttlex_front.sv =====
`timescale 1ns / 1ps

module ttlex_front #(
    parameter int LINE_BITS = 24
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_accept,
    input  logic                   in_mode,
    input  logic [7:0]             in_ch,
    output ttlex_pkg::entry_t      entry,
    output ttlex_pkg::front_stat_t stat
);

    // lexer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_IDENT  = 3'd1;
    localparam logic [2:0] ST_STRING = 3'd2;
    localparam logic [2:0] ST_NUMBER = 3'd3;
    localparam logic [2:0] ST_NUMDOT = 3'd4;

    // escape countdown codes
    localparam logic [2:0] ESC_NONE    = 3'd0;
    localparam logic [2:0] ESC_NUM     = 3'd2;
    localparam logic [2:0] ESC_PENDING = 3'd4;

    // characters
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_LBR   = 8'h7B;
    localparam logic [7:0] CH_RBR   = 8'h7D;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_N     = 8'h6E;

    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);

    typedef struct packed {
        logic                hit;
        ttlex_pkg::res_t     res;
        logic [2:0]          st;
        logic                cmt;
        logic                halt;
    } idle_t;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic ttlex_pkg::res_t mk_res(input logic [2:0] ev, input logic [1:0] kind,
                                               input logic [7:0] chr, input logic [1:0] err);
        ttlex_pkg::res_t r;
        r.ev   = ev;
        r.kind = kind;
        r.chr  = chr;
        r.err  = err;
        return r;
    endfunction

    // byte handled from the idle state
    function automatic idle_t idle_byte(input logic [7:0] c);
        idle_t o;
        o = '0;
        o.st = ST_IDLE;
        if (c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_LPAR || c == CH_RPAR) begin
            o.hit = 1'b0;
        end else if (is_letter(c)) begin
            o.hit = 1'b1;
            o.res = mk_res(ttlex_pkg::EV_CHAR, ttlex_pkg::KIND_IDENT, c, ttlex_pkg::ERR_NONE);
            o.st  = ST_IDENT;
        end else if (is_digit(c) || c == CH_MINUS) begin
            o.hit = 1'b1;
            o.res = mk_res(ttlex_pkg::EV_CHAR, ttlex_pkg::KIND_NUMBER, c, ttlex_pkg::ERR_NONE);
            o.st  = ST_NUMBER;
        end else if (c == CH_LBR) begin
            o.hit = 1'b1;
            o.res = mk_res(ttlex_pkg::EV_OPEN, ttlex_pkg::KIND_NONE, 8'h00, ttlex_pkg::ERR_NONE);
        end else if (c == CH_RBR) begin
            o.hit = 1'b1;
            o.res = mk_res(ttlex_pkg::EV_CLOSE, ttlex_pkg::KIND_NONE, 8'h00, ttlex_pkg::ERR_NONE);
        end else if (c == CH_QUOTE) begin
            o.st = ST_STRING;
        end else if (c == CH_SLASH) begin
            o.cmt = 1'b1;
        end else begin
            o.hit  = 1'b1;
            o.res  = mk_res(ttlex_pkg::EV_ERROR, ttlex_pkg::KIND_NONE, 8'h00, ttlex_pkg::ERR_SIGN);
            o.halt = 1'b1;
        end
        return o;
    endfunction

    logic [2:0]           st_reg, st_next;
    logic                 cmt_reg, cmt_next;
    logic [2:0]           esc_reg, esc_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic                 halt_reg, halt_next;

    logic                 hit0, hit1;
    ttlex_pkg::res_t      r0, r1;
    idle_t                idl;
    logic [7:0]           dec;
    logic [LINE_BITS+ttlex_pkg::LINE_OUT_BITS-1:0] line_ext;

    // lexer step for one request
    always_comb begin
        st_next   = st_reg;
        cmt_next  = cmt_reg;
        esc_next  = esc_reg;
        line_next = line_reg;
        halt_next = halt_reg;
        hit0      = 1'b0;
        hit1      = 1'b0;
        r0        = '0;
        r1        = '0;
        dec       = 8'h00;
        idl       = idle_byte(in_ch);
        if (halt_reg) begin
            hit0 = 1'b0;
        end else if (in_mode == ttlex_pkg::MODE_END) begin
            // flush pending token
            unique case (st_reg)
                ST_IDENT: begin
                    hit0 = 1'b1;
                    r0 = mk_res(ttlex_pkg::EV_DONE, ttlex_pkg::KIND_IDENT, 8'h00,
                                ttlex_pkg::ERR_NONE);
                end
                ST_NUMBER, ST_NUMDOT: begin
                    hit0 = 1'b1;
                    r0 = mk_res(ttlex_pkg::EV_DONE, ttlex_pkg::KIND_NUMBER, 8'h00,
                                ttlex_pkg::ERR_NONE);
                end
                ST_STRING: begin
                    hit0 = 1'b1;
                    r0 = mk_res(ttlex_pkg::EV_ERROR, ttlex_pkg::KIND_NONE, 8'h00,
                                ttlex_pkg::ERR_UNTERM);
                    halt_next = 1'b1;
                end
                default: begin
                    hit0 = 1'b0;
                end
            endcase
            st_next  = ST_IDLE;
            cmt_next = 1'b0;
            esc_next = ESC_NONE;
        end else begin
            // saturating line count
            if (in_ch == CH_LF && line_reg != '1) begin
                line_next = line_reg + LINE_ONE;
            end
            if (cmt_reg) begin
                if (in_ch == CH_SLASH) begin
                    cmt_next = 1'b0;
                end
            end else if (st_reg == ST_STRING) begin
                if (esc_reg != ESC_NONE) begin
                    // escape decode
                    priority if (in_ch == CH_T || in_ch == CH_N || in_ch == CH_QUOTE ||
                                 in_ch == CH_BSL) begin
                        priority if (in_ch == CH_T) begin
                            dec = CH_TAB;
                        end else if (in_ch == CH_N) begin
                            dec = CH_LF;
                        end else begin
                            dec = in_ch;
                        end
                        hit0 = 1'b1;
                        r0 = mk_res(ttlex_pkg::EV_CHAR, ttlex_pkg::KIND_STRING, dec,
                                    ttlex_pkg::ERR_NONE);
                        esc_next = (esc_reg == ESC_PENDING) ? ESC_NONE : esc_reg - 3'd1;
                    end else if (is_digit(in_ch)) begin
                        esc_next = (esc_reg == ESC_PENDING) ? ESC_NUM : esc_reg - 3'd1;
                    end else begin
                        hit0 = 1'b1;
                        r0 = mk_res(ttlex_pkg::EV_ERROR, ttlex_pkg::KIND_NONE, 8'h00,
                                    ttlex_pkg::ERR_ESCAPE);
                        halt_next = 1'b1;
                    end
                end else if (in_ch == CH_BSL) begin
                    esc_next = ESC_PENDING;
                end else if (in_ch == CH_QUOTE) begin
                    hit0 = 1'b1;
                    r0 = mk_res(ttlex_pkg::EV_DONE, ttlex_pkg::KIND_STRING, 8'h00,
                                ttlex_pkg::ERR_NONE);
                    st_next = ST_IDLE;
                end else begin
                    hit0 = 1'b1;
                    r0 = mk_res(ttlex_pkg::EV_CHAR, ttlex_pkg::KIND_STRING, in_ch,
                                ttlex_pkg::ERR_NONE);
                end
            end else if (st_reg == ST_IDENT) begin
                hit0 = 1'b1;
                if (is_letter(in_ch) || is_digit(in_ch)) begin
                    r0 = mk_res(ttlex_pkg::EV_CHAR, ttlex_pkg::KIND_IDENT, in_ch,
                                ttlex_pkg::ERR_NONE);
                end else begin
                    // token ends, byte reread from idle
                    r0 = mk_res(ttlex_pkg::EV_DONE, ttlex_pkg::KIND_IDENT, 8'h00,
                                ttlex_pkg::ERR_NONE);
                    hit1      = idl.hit;
                    r1        = idl.res;
                    st_next   = idl.st;
                    cmt_next  = idl.cmt;
                    halt_next = idl.halt;
                end
            end else if (st_reg == ST_NUMBER || st_reg == ST_NUMDOT) begin
                hit0 = 1'b1;
                if (is_digit(in_ch)) begin
                    r0 = mk_res(ttlex_pkg::EV_CHAR, ttlex_pkg::KIND_NUMBER, in_ch,
                                ttlex_pkg::ERR_NONE);
                end else if (in_ch == CH_DOT && st_reg == ST_NUMBER) begin
                    r0 = mk_res(ttlex_pkg::EV_CHAR, ttlex_pkg::KIND_NUMBER, in_ch,
                                ttlex_pkg::ERR_NONE);
                    st_next = ST_NUMDOT;
                end else begin
                    r0 = mk_res(ttlex_pkg::EV_DONE, ttlex_pkg::KIND_NUMBER, 8'h00,
                                ttlex_pkg::ERR_NONE);
                    hit1      = idl.hit;
                    r1        = idl.res;
                    st_next   = idl.st;
                    cmt_next  = idl.cmt;
                    halt_next = idl.halt;
                end
            end else begin
                // idle and unused codes
                hit0      = idl.hit;
                r0        = idl.res;
                st_next   = idl.st;
                cmt_next  = idl.cmt;
                halt_next = idl.halt;
            end
        end
    end

    // queue entry
    assign line_ext    = {{ttlex_pkg::LINE_OUT_BITS{1'b0}}, line_next};
    assign entry.two   = hit1;
    assign entry.r0    = r0;
    assign entry.r1    = r1;
    assign entry.line  = line_ext[ttlex_pkg::LINE_OUT_BITS-1:0];
    assign stat.push   = in_accept && hit0;
    assign stat.halted = halt_reg;

    // lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            cmt_reg  <= 1'b0;
            esc_reg  <= ESC_NONE;
            line_reg <= LINE_ONE;
            halt_reg <= 1'b0;
        end else if (in_accept) begin
            st_reg   <= st_next;
            cmt_reg  <= cmt_next;
            esc_reg  <= esc_next;
            line_reg <= line_next;
            halt_reg <= halt_next;
        end
    end

endmodule

// ===== rtl/core/ttlex_queue.sv =====
`timescale 1ns / 1ps

module ttlex_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  ttlex_pkg::entry_t wr_entry,
    output logic              not_full,
    input  logic              pop,
    output logic              rd_valid,
    output ttlex_pkg::entry_t rd_entry
);

    localparam int AW = ttlex_pkg::QUEUE_AW;
    localparam int CW = ttlex_pkg::QUEUE_CW;
    localparam logic [AW-1:0] PTR_LAST = AW'(ttlex_pkg::QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(ttlex_pkg::QUEUE_DEPTH);

    ttlex_pkg::entry_t mem_reg [ttlex_pkg::QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign not_full = count_reg != CNT_FULL;
    assign rd_valid = count_reg != '0;
    assign rd_entry = mem_reg[rd_ptr_reg];
    assign do_push  = push && not_full;
    assign do_pop   = pop && rd_valid;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CW'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= wr_entry;
        end
    end

endmodule

// ===== rtl/core/ttlex_back.sv =====
`timescale 1ns / 1ps

module ttlex_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                q_valid,
    input  ttlex_pkg::entry_t                   q_entry,
    output logic                                q_pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ttlex_pkg::res_t                     out_res,
    output logic [ttlex_pkg::LINE_OUT_BITS-1:0] out_line,
    output logic                                out_last
);

    logic                                out_vld_reg, out_vld_next;
    ttlex_pkg::res_t                     out_res_reg, out_res_next;
    logic [ttlex_pkg::LINE_OUT_BITS-1:0] out_line_reg, out_line_next;
    logic                                out_last_reg, out_last_next;
    logic                                pend_vld_reg, pend_vld_next;
    ttlex_pkg::res_t                     pend_res_reg, pend_res_next;
    logic                                load;

    // output stage free or being drained
    assign load  = !out_vld_reg || out_ready;
    assign q_pop = load && !pend_vld_reg && q_valid;

    // second result waits in the pending slot
    always_comb begin
        out_vld_next  = out_vld_reg;
        out_res_next  = out_res_reg;
        out_line_next = out_line_reg;
        out_last_next = out_last_reg;
        pend_vld_next = pend_vld_reg;
        pend_res_next = pend_res_reg;
        if (load) begin
            if (pend_vld_reg) begin
                out_vld_next  = 1'b1;
                out_res_next  = pend_res_reg;
                out_last_next = 1'b1;
                pend_vld_next = 1'b0;
            end else if (q_valid) begin
                out_vld_next  = 1'b1;
                out_res_next  = q_entry.r0;
                out_line_next = q_entry.line;
                out_last_next = !q_entry.two;
                pend_vld_next = q_entry.two;
                pend_res_next = q_entry.r1;
            end else begin
                out_vld_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg  <= 1'b0;
            pend_vld_reg <= 1'b0;
        end else begin
            out_vld_reg  <= out_vld_next;
            pend_vld_reg <= pend_vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_res_reg  <= out_res_next;
        out_line_reg <= out_line_next;
        out_last_reg <= out_last_next;
        pend_res_reg <= pend_res_next;
    end

    assign out_valid = out_vld_reg;
    assign out_res   = out_res_reg;
    assign out_line  = out_line_reg;
    assign out_last  = out_last_reg;

endmodule
